@@ hdl/ufrd_pkg.sv @@
// ============================================================================
// UART frame resync deframer package
// Shared constants, types and helper functions for the deframer modules.
// ============================================================================
`default_nettype none

package ufrd_pkg;

    // Window sizing: the window is a circular buffer whose depth is the next
    // power of two at or above the largest frame.
    localparam int MAX_FRAME = 17;
    localparam int PTR_W     = $clog2(MAX_FRAME);
    localparam int WIN_DEPTH = 2 ** PTR_W;
    localparam int CNT_W     = $clog2(MAX_FRAME + 1);

    // Input queue depth between the front and the back.
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    // Header, tail and length constants.
    localparam logic [7:0] HDR_PRESS_0   = 8'h63;
    localparam logic [7:0] HDR_PRESS_1   = 8'h70;
    localparam logic [7:0] HDR_STATION_0 = 8'h61;
    localparam logic [7:0] HDR_STATION_1 = 8'h73;
    localparam logic [7:0] HDR_VER_0     = 8'h76;
    localparam logic [7:0] HDR_MEAS_1    = 8'h64;
    localparam logic [7:0] HDR_MOTOR_0   = 8'h6d;
    localparam logic [7:0] HDR_MOTOR_1   = 8'h6f;
    localparam logic [7:0] TAIL_SHORT    = 8'h6e;
    localparam logic [7:0] TAIL_LONG     = 8'h6c;

    localparam logic [CNT_W-1:0] LEN_PRESS   = CNT_W'(14);
    localparam logic [CNT_W-1:0] LEN_STATION = CNT_W'(16);
    localparam logic [CNT_W-1:0] LEN_MEAS    = CNT_W'(17);
    localparam logic [CNT_W-1:0] LEN_VER     = CNT_W'(8);
    localparam logic [CNT_W-1:0] LEN_MOTOR   = CNT_W'(12);
    localparam logic [CNT_W-1:0] LEN_NONE    = CNT_W'(0);

    // Frame kind codes.
    localparam logic [2:0] KIND_PRESS   = 3'd0;
    localparam logic [2:0] KIND_STATION = 3'd1;
    localparam logic [2:0] KIND_VERSION = 3'd2;
    localparam logic [2:0] KIND_MEAS    = 3'd3;
    localparam logic [2:0] KIND_MOTOR   = 3'd4;

    // Configuration register indexes.
    localparam int          CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b1;

    localparam logic [15:0] CRC_POLY_RESET  = 16'hA001;
    localparam logic [15:0] CRC_START_RESET = 16'hFFFF;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // One queued input transfer, already classified.
    typedef struct packed {
        logic       is_flush;
        logic [7:0] data;
    } q_item_t;

    // CRC settings handed to the back end.
    typedef struct packed {
        logic [15:0] poly;
        logic [15:0] start;
    } crc_cfg_t;

    // Frame length from the first two window bytes; zero for an unknown header.
    function automatic cnt_t hdr_len(input logic [7:0] a, input logic [7:0] b);
        cnt_t len;
        if (a == HDR_PRESS_0 && b == HDR_PRESS_1) len = LEN_PRESS;
        else if (a == HDR_STATION_0 && b == HDR_STATION_1) len = LEN_STATION;
        else if (a == HDR_VER_0 && b == HDR_MEAS_1) len = LEN_MEAS;
        else if (a == HDR_VER_0) len = LEN_VER;
        else if (a == HDR_MOTOR_0 && b == HDR_MOTOR_1) len = LEN_MOTOR;
        else len = LEN_NONE;
        return len;
    endfunction

    function automatic logic [2:0] kind_of(input logic [7:0] a, input cnt_t len);
        logic [2:0] k;
        if (a == HDR_PRESS_0) k = KIND_PRESS;
        else if (a == HDR_STATION_0) k = KIND_STATION;
        else if (a == HDR_VER_0 && len == LEN_VER) k = KIND_VERSION;
        else if (a == HDR_VER_0) k = KIND_MEAS;
        else k = KIND_MOTOR;
        return k;
    endfunction

    // One byte of a reflected CRC-16.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ufrd_front.sv @@
// ============================================================================
// UART frame resync deframer front end
// Accepts input transfers, tags them as byte or flush, and queues them.
// ============================================================================
`default_nettype none

module ufrd_front
    import ufrd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire logic [7:0] rx_byte,
    input  wire logic    flush,
    output logic         q_valid,
    output q_item_t      q_item,
    input  wire logic    q_pop
);

    q_item_t             q_mem [Q_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   fill_reg, fill_next;
    logic                push;
    logic                pop;
    q_item_t             new_item;

    assign in_ready = (fill_reg != QCNT_W'(Q_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // A flush carries no byte; its data is forced to zero.
    always_comb
    begin
        new_item.is_flush = flush;
        new_item.data     = flush ? 8'h00 : rx_byte;
    end

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = QCNT_W'(fill_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            fill_next = QCNT_W'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

`default_nettype wire

@@ hdl/ufrd_back.sv @@
// ============================================================================
// UART frame resync deframer back end
// Holds the byte window, scans for frames, checks CRC and emits results.
// ============================================================================
`default_nettype none

module ufrd_back
    import ufrd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire crc_cfg_t crc_cfg,
    input  wire logic     q_valid,
    input  wire q_item_t  q_item,
    output logic          q_pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output logic [7:0]    data_byte,
    output logic [2:0]    frame_kind,
    output logic          crc_bad,
    output logic          last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_HDR1,
        S_HDR2,
        S_TAIL,
        S_CRC,
        S_CLO,
        S_CHI,
        S_ERR,
        S_EMIT
    } state_t;

    state_t      state_reg, state_next;
    ptr_t        head_reg, head_next;
    cnt_t        count_reg, count_next;
    logic [7:0]  b0_reg, b0_next;
    cnt_t        len_reg, len_next;
    logic [2:0]  kind_reg, kind_next;
    cnt_t        idx_reg, idx_next;
    logic [15:0] crc_reg, crc_next;
    logic        lo_ok_reg, lo_ok_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_data_reg, out_data_next;
    logic [2:0]  out_kind_reg, out_kind_next;
    logic        out_bad_reg, out_bad_next;
    logic        out_last_reg, out_last_next;

    logic [7:0]  win_mem [WIN_DEPTH];
    logic [7:0]  rd_data_reg;
    ptr_t        rd_addr;
    ptr_t        wr_addr;
    logic        wr_en;
    logic        out_free;
    cnt_t        base_cnt;
    cnt_t        hlen;
    cnt_t        pay;
    logic [7:0]  tail_exp;
    logic        is_last;

    assign out_valid  = out_valid_reg;
    assign data_byte  = out_data_reg;
    assign frame_kind = out_kind_reg;
    assign crc_bad    = out_bad_reg;
    assign last       = out_last_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign pay      = cnt_t'(len_reg - cnt_t'(3));
    assign base_cnt = (count_reg >= cnt_t'(MAX_FRAME)) ? '0 : count_reg;
    assign hlen     = hdr_len(b0_reg, rd_data_reg);
    assign tail_exp = (kind_reg == KIND_VERSION) ? TAIL_SHORT : TAIL_LONG;
    assign is_last  = (idx_reg == cnt_t'(len_reg - cnt_t'(1)));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        b0_next        = b0_reg;
        len_next       = len_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        lo_ok_next     = lo_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_bad_next   = out_bad_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = ptr_t'(head_reg + ptr_t'(base_cnt));
        rd_addr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_item.is_flush)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = cnt_t'(base_cnt + cnt_t'(1));
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (count_reg < cnt_t'(2))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_HDR1;
                end
            end
            S_HDR1:
            begin
                b0_next    = rd_data_reg;
                rd_addr    = ptr_t'(head_reg + ptr_t'(1));
                state_next = S_HDR2;
            end
            S_HDR2:
            begin
                if (hlen == LEN_NONE || hlen > cnt_t'(MAX_FRAME))
                begin
                    head_next  = ptr_t'(head_reg + ptr_t'(1));
                    count_next = cnt_t'(count_reg - cnt_t'(1));
                    state_next = S_SCAN;
                end
                else if (count_reg < hlen)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    len_next   = hlen;
                    kind_next  = kind_of(b0_reg, hlen);
                    rd_addr    = ptr_t'(head_reg + ptr_t'(hlen - cnt_t'(1)));
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (rd_data_reg != tail_exp)
                begin
                    head_next  = ptr_t'(head_reg + ptr_t'(1));
                    count_next = cnt_t'(count_reg - cnt_t'(1));
                    state_next = S_SCAN;
                end
                else
                begin
                    crc_next   = crc_cfg.start;
                    idx_next   = '0;
                    state_next = S_CRC;
                end
            end
            S_CRC:
            begin
                // Data for idx is present; the next address is already issued.
                crc_next = crc_byte(crc_reg, rd_data_reg, crc_cfg.poly);
                idx_next = cnt_t'(idx_reg + cnt_t'(1));
                rd_addr  = ptr_t'(head_reg + ptr_t'(idx_reg + cnt_t'(1)));
                if (cnt_t'(idx_reg + cnt_t'(1)) == pay)
                begin
                    state_next = S_CLO;
                end
            end
            S_CLO:
            begin
                lo_ok_next = (rd_data_reg == crc_reg[7:0]);
                rd_addr    = ptr_t'(head_reg + ptr_t'(pay) + ptr_t'(1));
                state_next = S_CHI;
            end
            S_CHI:
            begin
                if (lo_ok_reg && rd_data_reg == crc_reg[15:8])
                begin
                    idx_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = 8'h00;
                    out_kind_next  = kind_reg;
                    out_bad_next   = 1'b1;
                    out_last_next  = 1'b1;
                    head_next      = ptr_t'(head_reg + ptr_t'(len_reg));
                    count_next     = cnt_t'(count_reg - len_reg);
                    state_next     = S_SCAN;
                end
            end
            S_EMIT:
            begin
                rd_addr = ptr_t'(head_reg + ptr_t'(idx_reg));
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data_reg;
                    out_kind_next  = kind_reg;
                    out_bad_next   = 1'b0;
                    out_last_next  = is_last;
                    rd_addr        = ptr_t'(head_reg + ptr_t'(idx_reg + cnt_t'(1)));
                    if (is_last)
                    begin
                        head_next  = ptr_t'(head_reg + ptr_t'(len_reg));
                        count_next = cnt_t'(count_reg - len_reg);
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        idx_next = cnt_t'(idx_reg + cnt_t'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            b0_reg        <= '0;
            len_reg       <= '0;
            kind_reg      <= '0;
            idx_reg       <= '0;
            crc_reg       <= '0;
            lo_ok_reg     <= 1'b0;
            out_data_reg  <= '0;
            out_kind_reg  <= '0;
            out_bad_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            b0_reg        <= b0_next;
            len_reg       <= len_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            lo_ok_reg     <= lo_ok_next;
            out_data_reg  <= out_data_next;
            out_kind_reg  <= out_kind_next;
            out_bad_reg   <= out_bad_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Window memory: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_mem[wr_addr] <= q_item.data;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/uart_frame_resync_deframer.sv @@
// ============================================================================
// UART frame resync deframer
// Finds length-coded frames in a received byte stream, checks their CRC-16
// and delivers validated frames byte by byte, or one error result per bad frame.
// ============================================================================
//
// Received bytes go into a queue of two entries and from there into a window
// of up to 17 bytes, held as a circular buffer in a small memory with one
// read and one write port. A byte is stored from the queue in the idle
// state, and each header look passes through the scan and header states.
// A byte dropped while resynchronizing, for an unknown header or a failed
// tail check, starts another header look from the next window byte.
// When a frame of length L is complete, its tail is checked, the CRC runs
// one byte per cycle over L-3 bytes, the stored CRC is compared low byte
// first, then high byte, and the good frame then leaves at one byte per
// cycle while the output is not stalled (a bad frame gives a single result).
// The memory read port is shared by scanning, CRC and output. A flush is
// taken from the queue and empties the window. The output is a register, so
// the queue keeps taking transfers while a result waits, until its two
// entries are full. The configuration port is always ready; index 0 writes
// the CRC polynomial (reflected form, reset 0xA001) and index 1 the CRC
// start value (reset 0xFFFF). Write them only while the block is idle.
//
`default_nettype none

module uart_frame_resync_deframer
    import ufrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 flush,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                data_byte,
    output logic [2:0]                frame_kind,
    output logic                      crc_bad,
    output logic                      last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_data
);

    crc_cfg_t cfg_reg, cfg_next;
    logic     q_valid;
    q_item_t  q_item;
    logic     q_pop;

    // Configuration writes complete in the cycle they are offered.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLY:  cfg_next.poly  = cfg_data;
                CFG_START: cfg_next.start = cfg_data;
                default:   cfg_next       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly  <= CRC_POLY_RESET;
            cfg_reg.start <= CRC_START_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end takes input transfers and queues them.
    ufrd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .flush    (flush),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // The back end owns the window, the scan, the CRC and the result register.
    ufrd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .crc_cfg    (cfg_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .frame_kind (frame_kind),
        .crc_bad    (crc_bad),
        .last       (last)
    );

endmodule

`default_nettype wire

@@ hdl/ufrd_checker.sv @@
// ============================================================================
// UART frame resync deframer checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
`default_nettype none

module ufrd_checker
    import ufrd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] data_byte,
    input wire logic [2:0] frame_kind,
    input wire logic       crc_bad,
    input wire logic       last
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(data_byte) && $stable(frame_kind)
            && $stable(crc_bad) && $stable(last))
        else $error("result changed while stalled");

    // A CRC failure is a single, zeroed result that ends its run.
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && crc_bad |-> last && data_byte == 8'h00)
        else $error("malformed CRC error result");

    // Only defined frame kinds reach the output.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_kind <= KIND_MOTOR)
        else $error("frame kind out of range");

    // No result is offered while reset is held.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind uart_frame_resync_deframer ufrd_checker u_ufrd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data_byte  (data_byte),
    .frame_kind (frame_kind),
    .crc_bad    (crc_bad),
    .last       (last)
);

`default_nettype wire
